// ----- src/fvc16_pkg.sv -----
// ----------------------------------------------------------------------------
// fvc16_pkg
// Shared types, constants and the byte-wide CRC-16 update for the frame
// validator.
// ----------------------------------------------------------------------------
`default_nettype none

package fvc16_pkg;

    localparam int POS_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 16;
    localparam int ERR_W   = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CRC_W-1:0]  crc_t;
    typedef logic [ERR_W-1:0]  err_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam crc_t CRC_INIT = 16'hFFFF;
    localparam crc_t CRC_POLY = 16'h1021;
    localparam crc_t CRC_TOP  = 16'h8000;

    localparam err_t ERR_NONE        = 2'd0;
    localparam err_t ERR_BAD_MAGIC   = 2'd1;
    localparam err_t ERR_BAD_VERSION = 2'd2;
    localparam err_t ERR_BAD_CRC     = 2'd3;

    localparam cfg_idx_t REG_FRAME_MAGIC      = 2'd0;
    localparam cfg_idx_t REG_PROTOCOL_VERSION = 2'd1;

    localparam byte_t MAGIC_RESET   = 8'h00;
    localparam byte_t VERSION_RESET = 8'h01;

    // Advance the CRC by one byte, most significant bit first.
    function automatic crc_t crc_byte(input crc_t crc_in, input byte_t data);
        crc_t c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if ((c & CRC_TOP) != '0)
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/frame_validator_crc16_unit.sv -----
// ----------------------------------------------------------------------------
// frame_validator_crc16_unit
// Checks fixed-length frames received one byte per request: magic, version
// and a little-endian CRC-16 (poly 0x1021, init 0xFFFF) over every byte before the CRC.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid/byte_ready): rx_byte plus frame_first, which
//   restarts the frame at position 0 and drops any partial frame.
//   Result channel (result_valid/result_ready): error_code and frame_ok,
//   one request per frame, produced by the frame's final byte only.
//   Config channel (cfg_valid/cfg_ready): cfg_index 0 sets the magic byte,
//   1 the protocol version; other indexes are ignored. cfg_ready is always
//   high. Write only while no frame is in progress.
// Timing:
//   A new byte may be accepted every cycle while byte_ready is high; a
//   held result lowers it. The result appears in the result register the
//   cycle after the final byte is accepted. Throughput is one byte per
//   cycle while no held result stalls the byte channel.
// Reset:
//   Position 0, CRC 0xFFFF, no error, magic 0x00, version 0x01, no result.
// Stall:
//   A held result blocks new bytes only while result_ready is low; when the
//   receiver takes it, a new byte is accepted in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_validator_crc16_unit
    import fvc16_pkg::*;
#(
    parameter int FRAME_BYTES = 12
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,

    input  wire logic           byte_valid,
    output logic                byte_ready,
    input  wire logic [7:0]     rx_byte,
    input  wire logic           frame_first,

    output logic                result_valid,
    input  wire logic           result_ready,
    output logic [1:0]          error_code,
    output logic                frame_ok,

    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [7:0]     cfg_data
);

    localparam pos_t CRC_LOW_POS = POS_W'(FRAME_BYTES - 2);

    pos_t  pos_reg,   pos_next;
    crc_t  crc_reg,   crc_next;
    err_t  err_reg,   err_next;
    byte_t low_reg,   low_next;
    byte_t magic_reg, version_reg;

    logic  result_valid_reg, result_valid_next;
    err_t  result_err_reg,   result_err_next;

    logic  accept;
    pos_t  pos_cur;
    crc_t  crc_cur;
    err_t  err_cur;
    err_t  err_chk;
    crc_t  crc_got;

    assign byte_ready   = !result_valid_reg || result_ready;
    assign accept       = byte_valid && byte_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign error_code   = result_err_reg;
    assign frame_ok     = (result_err_reg == ERR_NONE);

    always_comb
    begin
        pos_cur = frame_first ? '0 : pos_reg;
        crc_cur = frame_first ? CRC_INIT : crc_reg;
        err_cur = frame_first ? ERR_NONE : err_reg;
        crc_got = {rx_byte, low_reg};

        err_chk = err_cur;
        if (pos_cur == POS_W'(0) && rx_byte != magic_reg && err_cur == ERR_NONE)
        begin
            err_chk = ERR_BAD_MAGIC;
        end
        if (pos_cur == POS_W'(1) && rx_byte != version_reg && err_cur == ERR_NONE)
        begin
            err_chk = ERR_BAD_VERSION;
        end

        pos_next          = pos_reg;
        crc_next          = crc_reg;
        err_next          = err_reg;
        low_next          = low_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_err_next   = result_err_reg;

        if (accept)
        begin
            if (pos_cur < CRC_LOW_POS)
            begin
                crc_next = crc_byte(crc_cur, rx_byte);
                err_next = err_chk;
                pos_next = pos_cur + POS_W'(1);
            end
            else if (pos_cur == CRC_LOW_POS)
            begin
                low_next = rx_byte;
                err_next = err_chk;
                pos_next = pos_cur + POS_W'(1);
            end
            else
            begin
                // final byte: report and restart
                result_valid_next = 1'b1;
                result_err_next   = (crc_got != crc_cur && err_chk == ERR_NONE)
                                    ? ERR_BAD_CRC : err_chk;
                pos_next = '0;
                crc_next = CRC_INIT;
                err_next = ERR_NONE;
                low_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            crc_reg          <= CRC_INIT;
            err_reg          <= ERR_NONE;
            low_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_err_reg   <= ERR_NONE;
        end
        else
        begin
            pos_reg          <= pos_next;
            crc_reg          <= crc_next;
            err_reg          <= err_next;
            low_reg          <= low_next;
            result_valid_reg <= result_valid_next;
            result_err_reg   <= result_err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= MAGIC_RESET;
            version_reg <= VERSION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_MAGIC:      magic_reg   <= cfg_data;
                REG_PROTOCOL_VERSION: version_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) < FRAME_BYTES)
        else $error("byte position beyond frame length");

    a_first_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_first) |=> (pos_reg == POS_W'(1)))
        else $error("frame start did not advance to position 1");

    a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(accept))
        else $error("result raised without an accepted byte");

    a_result_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> (pos_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame state not restarted after final byte");

endmodule

`default_nettype wire
